// File: sv/pgcb_pkg.sv
// ----------------------------------------------------------------------------
// PCM gain with clip backoff: shared definitions
// Formats, register indexes, widths and the gain table built at elaboration.
// ----------------------------------------------------------------------------
package pgcb_pkg;

	localparam int MIN_GAIN_STEP      = -64;
	localparam int DB_STEP_HUNDREDTHS = 50;
	localparam int GAIN_FLOOR_INT     = (MIN_GAIN_STEP < -64) ? -64 : MIN_GAIN_STEP;

	localparam int STEP_W     = 7;
	localparam int GAIN_AW    = STEP_W;
	localparam int GAIN_DEPTH = 1 << GAIN_AW;
	localparam int GAIN_W     = 32;
	localparam int FMT_W      = 3;
	localparam int WORD_W     = 32;
	localparam int MAG_W      = 38;
	localparam int PROD_LO_W  = 64;
	localparam int PROD_HI_W  = 38;
	localparam int P_W        = 46;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic signed [STEP_W-1:0] GAIN_FLOOR = STEP_W'(GAIN_FLOOR_INT);

	localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN    = 1'b1;

	localparam longint unsigned LN10_Q30 = 64'd2472381918;
	localparam longint unsigned CAP_Q30  = 64'h7FFFFFFF << 6;

	typedef logic [GAIN_DEPTH-1:0][GAIN_W-1:0] gain_table_t;

	// Gain factor 10^(step*dB/20) in Q8.24, from a Q30 Taylor series.
	function automatic logic [GAIN_W-1:0] gain_entry(input int step);
		int k;
		int q;
		int r;
		int n;
		int i;
		longint unsigned y;
		longint unsigned term;
		longint unsigned v;
		logic sat;
		k = step * DB_STEP_HUNDREDTHS;
		if (k >= 0) begin
			q = k / 2000;
		end else begin
			q = -((-k + 1999) / 2000);
		end
		r = k - q * 2000;
		y = (64'(r) * LN10_Q30) / 64'd2000;
		term = 64'd1 << 30;
		v = term;
		for (n = 1; n <= 40; n++) begin
			term = ((term * y) >> 30) / 64'(n);
			v = v + term;
		end
		sat = 1'b0;
		for (i = 0; i < q; i++) begin
			if (!sat) begin
				v = v * 64'd10;
				if (v > CAP_Q30) begin
					v = CAP_Q30;
					sat = 1'b1;
				end
			end
		end
		for (i = 0; i < -q; i++) begin
			v = v / 64'd10;
		end
		v = (v + 64'd32) >> 6;
		if (v > 64'h7FFFFFFF) begin
			v = 64'h7FFFFFFF;
		end
		return v[GAIN_W-1:0];
	endfunction

	function automatic gain_table_t build_gain_table();
		gain_table_t t;
		int i;
		for (i = 0; i < GAIN_DEPTH; i++) begin
			t[i] = gain_entry((i >= GAIN_DEPTH / 2) ? i - GAIN_DEPTH : i);
		end
		return t;
	endfunction

	localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

// File: sv/pgcb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pgcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/pcm_gain_with_clip_backoff_top.sv
// ----------------------------------------------------------------------------
// PCM gain with clip backoff
// Normalizes one PCM or float sample to Q8.31, scales it by a gain from a
// table RAM and lowers the running gain step while the product clips.
//
//   channel   signals                                   direction
//   sample    sample_valid, sample_stall, sample_word   in, stall out
//   result    result_valid, result_stall, out_word,     out, stall in
//             clipped, gain_used
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  in, ready out
//
// Each attempt goes through the table read, the registered multiply and the
// clip check; a gain retry lowers the step and repeats all three.
// After reset all 128 gain table entries are loaded into the RAM; samples stall then.
// The result sits in an output register, so the next sample transfers while
// a stalled result waits; a finished item waits only for that register.
// ----------------------------------------------------------------------------
module pcm_gain_with_clip_backoff_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [pgcb_pkg::WORD_W-1:0]          sample_word,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [pgcb_pkg::WORD_W-1:0]          out_word,
	output logic                                 clipped,
	output logic signed [pgcb_pkg::STEP_W-1:0]   gain_used,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pgcb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pgcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import pgcb_pkg::*;

	typedef enum logic [3:0] {
		S_INIT  = 4'b0001,
		S_IDLE  = 4'b0010,
		S_MUL   = 4'b0100,
		S_CHECK = 4'b1000
	} state_t;

	state_t state_q;
	logic [GAIN_AW-1:0] init_cnt_q;
	logic [FMT_W-1:0] format_q;
	logic signed [STEP_W-1:0] gain_step_q;
	logic neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [PROD_LO_W-1:0] prod_lo_q;
	logic [PROD_HI_W-1:0] prod_hi_q;
	logic out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic clipped_q;
	logic signed [STEP_W-1:0] gain_used_q;

	logic sample_xfer;
	logic cfg_xfer;
	logic ram_wr_en;
	logic ram_rd_en;
	logic [GAIN_AW-1:0] ram_rd_addr;
	logic [GAIN_W-1:0] ram_rd_data;

	logic dec_neg;
	logic [MAG_W-1:0] dec_mag;
	logic signed [32:0] pcm_val;
	logic [32:0] pcm_abs;
	logic [7:0] f_exp;
	logic [MAG_W-1:0] f_base;

	logic [P_W-1:0] prod;
	logic clip;
	logic retry;
	logic finish;
	logic [15:0] m16;
	logic [15:0] r16;
	logic [WORD_W-1:0] m32;
	logic [WORD_W-1:0] res;

	// A pending register write goes first, so a sample never shares its edge.
	assign sample_stall = (state_q != S_IDLE) || cfg_valid;
	assign sample_xfer  = sample_valid && !sample_stall;
	assign cfg_ready    = (state_q == S_IDLE) || (state_q == S_INIT);
	assign cfg_xfer     = cfg_valid && cfg_ready;

	// Sample decode to sign and Q.31 magnitude.
	always_comb begin
		pcm_val = '0;
		pcm_abs = '0;
		f_exp   = sample_word[30:23];
		f_base  = {14'b0, 1'b1, sample_word[22:0]} << 14;
		dec_neg = sample_word[31];
		dec_mag = '0;
		case (format_q)
			FMT_U8: begin
				pcm_val = 33'(sample_word[7:0]) - 33'd128;
			end
			FMT_S16: begin
				pcm_val = 33'(signed'(sample_word[15:0]));
			end
			FMT_S24: begin
				pcm_val = 33'(signed'(sample_word[23:0]));
			end
			default: begin
				pcm_val = 33'(signed'(sample_word));
			end
		endcase
		pcm_abs = pcm_val[32] ? 33'(-pcm_val) : 33'(pcm_val);
		case (format_q)
			FMT_U8: begin
				dec_neg = pcm_val[32];
				dec_mag = MAG_W'(pcm_abs) << 24;
			end
			FMT_S16: begin
				dec_neg = pcm_val[32];
				dec_mag = MAG_W'(pcm_abs) << 16;
			end
			FMT_S24: begin
				dec_neg = pcm_val[32];
				dec_mag = MAG_W'(pcm_abs) << 8;
			end
			FMT_F32: begin
				if (f_exp == 8'd255) begin
					dec_mag = (sample_word[22:0] != '0) ? '0 : '1;
				end else if (f_exp >= 8'd134) begin
					dec_mag = '1;
				end else if (f_exp >= 8'd96) begin
					dec_mag = f_base >> (8'd133 - f_exp);
				end else begin
					dec_mag = '0;
				end
			end
			default: begin
				dec_mag = MAG_W'(pcm_abs);
			end
		endcase
		if (dec_mag == '0) begin
			dec_neg = 1'b0;
		end
	end

	always_comb begin
		prod   = {prod_hi_q, 8'b0} + {6'b0, prod_lo_q[PROD_LO_W-1:24]};
		clip   = prod > P_W'(64'h80000000);
		retry  = (state_q == S_CHECK) && clip && (gain_step_q > GAIN_FLOOR);
		finish = (state_q == S_CHECK) && !retry && (!out_valid_q || !result_stall);
		m16    = prod[31:16];
		m32    = prod[31:0];
		if (format_q == FMT_U8 || format_q == FMT_S16) begin
			if (clip) begin
				r16 = neg_q ? 16'h8000 : 16'h7FFF;
			end else if (neg_q) begin
				r16 = -m16;
			end else begin
				r16 = (m16 > 16'h7FFF) ? 16'h7FFF : m16;
			end
			res = {16'b0, r16};
		end else begin
			r16 = '0;
			if (clip) begin
				res = neg_q ? 32'h80000000 : 32'h7FFFFFFF;
			end else if (neg_q) begin
				res = -m32;
			end else begin
				res = (m32 > 32'h7FFFFFFF) ? 32'h7FFFFFFF : m32;
			end
		end
	end

	assign ram_wr_en   = (state_q == S_INIT);
	assign ram_rd_en   = sample_xfer || retry;
	assign ram_rd_addr = retry ? GAIN_AW'(gain_step_q - 7'sd1) : GAIN_AW'(gain_step_q);

	pgcb_ram #(
		.WIDTH(GAIN_W),
		.DEPTH(GAIN_DEPTH)
	) u_gain_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (init_cnt_q),
		.wr_data (GAIN_TABLE[init_cnt_q]),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			format_q    <= FMT_S16;
			gain_step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				case (cfg_index)
					CFG_SAMPLE_FORMAT: format_q <= cfg_data[FMT_W-1:0];
					CFG_START_GAIN:    gain_step_q <= signed'(cfg_data[STEP_W-1:0]);
					default:           format_q <= format_q;
				endcase
			end
			if (retry) begin
				gain_step_q <= gain_step_q - 7'sd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (&init_cnt_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (sample_xfer) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (retry) begin
						state_q <= S_MUL;
					end else if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			neg_q <= dec_neg;
			mag_q <= dec_mag;
		end
		if (state_q == S_MUL) begin
			prod_lo_q <= {32'b0, mag_q[31:0]} * {32'b0, ram_rd_data};
			prod_hi_q <= {32'b0, mag_q[MAG_W-1:32]} * {6'b0, ram_rd_data};
		end
		if (finish) begin
			out_word_q  <= res;
			clipped_q   <= clip;
			gain_used_q <= gain_step_q;
		end
	end

	assign result_valid = out_valid_q;
	assign out_word     = out_word_q;
	assign clipped      = clipped_q;
	assign gain_used    = gain_used_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && clipped) |-> (gain_used <= GAIN_FLOOR))
		else $error("Clipped result delivered above the floor gain step.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && clipped) |-> (out_word == 32'h7FFFFFFF || out_word == 32'h80000000 ||
			out_word == 32'h00007FFF || out_word == 32'h00008000))
		else $error("Clipped result is not a saturation value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> $past(ram_rd_en))
		else $error("Multiply stage entered without a gain table read.");

endmodule
